### rtl/ifre_pkg.sv
// Shared types and constants of the image flip/rotate engine.
// Holds the item structs, opcodes, mode codes and register indexes.
// No dependencies.
package ifre_pkg;

   // Parameter defaults
   localparam int MAX_ROWS_DEF   = 256;
   localparam int MAX_COLS_DEF   = 256;
   localparam int PIXEL_BITS_DEF = 32;

   // Fixed widths of the item and register fields
   localparam int PIXEL_W     = 32;
   localparam int CFG_DATA_W  = 9;
   localparam int CSR_INDEX_W = 2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_MODE = 2'd0;
   localparam csr_index_type CSR_ROWS = 2'd1;
   localparam csr_index_type CSR_COLS = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef logic [2:0] mode_type;
   localparam mode_type MODE_FLIP_V  = 3'd0;
   localparam mode_type MODE_FLIP_H  = 3'd1;
   localparam mode_type MODE_ROT_CCW = 3'd2;
   localparam mode_type MODE_ROT_CW  = 3'd3;
   localparam mode_type MODE_ROT_180 = 3'd4;

   localparam mode_type              MODE_RESET = MODE_FLIP_V;
   localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 9'd256;

   typedef struct packed {
      logic               opcode;
      logic [PIXEL_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               last_pixel;
      logic               not_ready;
   } rsp_type;

   // Frame events raised by the load side on an accepted load beat
   typedef struct packed {
      logic first;   // load of source pixel (0,0)
      logic done;    // load of the final source pixel
   } load_evt_type;

endpackage

### rtl/image_flip_rotate_engine_unit.sv
// Top level of the image flip/rotate engine: config registers, load address
// generator, read sequencer and the frame store. Depends on ifre_pkg, ifre_ram,
// ifre_load_agen and ifre_read_seq.
//
//   channel   ports                                        handshake
//   -------   ------------------------------------------   --------------------------
//   request   start, busy, req_item                        start && !busy
//   response  rsp_valid, rsp_item                          one-cycle strobe, no stall
//   config    csr_valid, csr_ready, csr_index, csr_wdata   csr_valid && csr_ready
//
// One beat per clock. A load is written to the frame store the cycle after it
// is taken; a read returns its result on the cycle after it is taken, set by
// the registered read port of the store. busy stays low and csr_ready high.
// Reset clears counters and flags and restores the config defaults; the store
// needs no clearing pass; reads come from it only after a full frame was loaded.
module image_flip_rotate_engine_unit #(
   parameter int MAX_ROWS   = ifre_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = ifre_pkg::MAX_COLS_DEF,
   parameter int PIXEL_BITS = ifre_pkg::PIXEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ifre_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   output ifre_pkg::rsp_type                   rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  ifre_pkg::csr_index_type             csr_index,
   input  logic [ifre_pkg::CFG_DATA_W-1:0]     csr_wdata
);
   import ifre_pkg::*;

   localparam int IW = $clog2(MAX_ROWS);
   localparam int JW = $clog2(MAX_COLS);
   localparam int AW = $clog2(MAX_ROWS*MAX_COLS);

   mode_type              mode_ff, mode_in;
   logic [CFG_DATA_W-1:0] row_count_ff, row_count_in;
   logic [CFG_DATA_W-1:0] col_count_ff, col_count_in;
   logic                  csr_write, cfg_restart;
   logic [IW-1:0]         rows_m1;
   logic [JW-1:0]         cols_m1;
   logic                  load_acc, read_acc;
   load_evt_type          evt;
   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [PIXEL_BITS-1:0] wr_data, rd_data;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign load_acc  = start && !busy && (req_item.opcode == OP_LOAD);
   assign read_acc  = start && !busy && (req_item.opcode == OP_READ);

   assign csr_write   = csr_valid && csr_ready;
   assign cfg_restart = csr_write && (csr_index inside {CSR_MODE, CSR_ROWS, CSR_COLS});

   always_comb begin
      mode_in      = mode_ff;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MODE: mode_in      = csr_wdata[2:0];
            CSR_ROWS: row_count_in = csr_wdata;
            CSR_COLS: col_count_in = csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         row_count_ff <= SIZE_RESET;
         col_count_ff <= SIZE_RESET;
      end else begin
         mode_ff      <= mode_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // zero counts act as one, oversize counts saturate
   always_comb begin
      if (row_count_ff == '0) begin
         rows_m1 = '0;
      end else if (32'(row_count_ff) > 32'(MAX_ROWS)) begin
         rows_m1 = IW'(MAX_ROWS - 1);
      end else begin
         rows_m1 = IW'(row_count_ff - CFG_DATA_W'(1));
      end
      if (col_count_ff == '0) begin
         cols_m1 = '0;
      end else if (32'(col_count_ff) > 32'(MAX_COLS)) begin
         cols_m1 = JW'(MAX_COLS - 1);
      end else begin
         cols_m1 = JW'(col_count_ff - CFG_DATA_W'(1));
      end
   end

   ifre_load_agen #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_load_agen (
      .clock   (clock),
      .reset   (reset),
      .restart (cfg_restart),
      .load    (load_acc),
      .pixel   (req_item.pixel_in[PIXEL_BITS-1:0]),
      .mode    (mode_ff),
      .rows_m1 (rows_m1),
      .cols_m1 (cols_m1),
      .evt     (evt),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   ifre_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_ROWS*MAX_COLS)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ifre_read_seq #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_read_seq (
      .clock     (clock),
      .reset     (reset),
      .restart   (cfg_restart),
      .read      (read_acc),
      .evt       (evt),
      .rows_m1   (rows_m1),
      .cols_m1   (cols_m1),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // a result beat only ever follows an accepted read
   a_rsp_follows_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(read_acc))
      else $error("result beat without a read");

   // a register write restarts the frame, so a read right after it is not ready
   a_restart_not_ready: assert property (@(posedge clock) disable iff (reset)
      cfg_restart ##1 read_acc |=> rsp_item.not_ready)
      else $error("read after restart returned store data");

   a_not_ready_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.not_ready) |->
         (rsp_item.pixel_out == '0 && !rsp_item.last_pixel))
      else $error("not-ready result carries data");

endmodule

### rtl/ifre_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first on a same-address collision. No dependencies.
module ifre_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ifre_load_agen.sv
// Load side: source row/column counters and the transformed store address.
// Registers one write request per load beat. Depends on ifre_pkg.
module ifre_load_agen #(
   parameter int MAX_ROWS   = 256,
   parameter int MAX_COLS   = 256,
   parameter int PIXEL_BITS = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       restart,
   input  logic                                       load,
   input  logic [PIXEL_BITS-1:0]                      pixel,
   input  ifre_pkg::mode_type                         mode,
   input  logic [$clog2(MAX_ROWS)-1:0]                rows_m1,
   input  logic [$clog2(MAX_COLS)-1:0]                cols_m1,
   output ifre_pkg::load_evt_type                     evt,
   output logic                                       wr_en,
   output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]       wr_addr,
   output logic [PIXEL_BITS-1:0]                      wr_data
);
   import ifre_pkg::*;

   localparam int IW = $clog2(MAX_ROWS);
   localparam int JW = $clog2(MAX_COLS);
   localparam int AW = $clog2(MAX_ROWS*MAX_COLS);

   logic [IW-1:0]         row_ff, row_in;
   logic [JW-1:0]         col_ff, col_in;
   logic                  wr_en_ff, wr_en_in;
   logic [AW-1:0]         wr_addr_ff;
   logic [PIXEL_BITS-1:0] wr_data_ff;

   logic [AW-1:0] row_stride, col_stride;
   logic [AW-1:0] major, stride, minor, addr;
   logic          col_wrap, row_wrap;

   assign row_stride = AW'(rows_m1) + AW'(1);
   assign col_stride = AW'(cols_m1) + AW'(1);

   // address = major * stride + minor
   always_comb begin
      case (mode)
         MODE_FLIP_V: begin
            major  = AW'(rows_m1 - row_ff);
            stride = col_stride;
            minor  = AW'(col_ff);
         end
         MODE_FLIP_H: begin
            major  = AW'(row_ff);
            stride = col_stride;
            minor  = AW'(cols_m1 - col_ff);
         end
         MODE_ROT_CCW: begin
            major  = AW'(cols_m1 - col_ff);
            stride = row_stride;
            minor  = AW'(row_ff);
         end
         MODE_ROT_CW: begin
            major  = AW'(col_ff);
            stride = row_stride;
            minor  = AW'(rows_m1 - row_ff);
         end
         MODE_ROT_180: begin
            major  = AW'(rows_m1 - row_ff);
            stride = col_stride;
            minor  = AW'(cols_m1 - col_ff);
         end
         default: begin
            // unknown modes store the frame unchanged
            major  = AW'(row_ff);
            stride = col_stride;
            minor  = AW'(col_ff);
         end
      endcase
      addr = major * stride + minor;
   end

   assign col_wrap = (col_ff == cols_m1);
   assign row_wrap = (row_ff == rows_m1);

   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      wr_en_in  = load;
      evt.first = load && (row_ff == '0) && (col_ff == '0);
      evt.done  = load && col_wrap && row_wrap;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (load) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + IW'(1);
         end else begin
            col_in = col_ff + JW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         wr_en_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         wr_en_ff <= wr_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         wr_addr_ff <= addr;
         wr_data_ff <= pixel;
      end
   end

   assign wr_en   = wr_en_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_data = wr_data_ff;

endmodule

### rtl/ifre_read_seq.sv
// Read side: frame-loaded flag, output read pointer, store read and response.
// Forwards a write still in flight to the same entry. Depends on ifre_pkg.
module ifre_read_seq #(
   parameter int MAX_ROWS   = 256,
   parameter int MAX_COLS   = 256,
   parameter int PIXEL_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 restart,
   input  logic                                 read,
   input  ifre_pkg::load_evt_type               evt,
   input  logic [$clog2(MAX_ROWS)-1:0]          rows_m1,
   input  logic [$clog2(MAX_COLS)-1:0]          cols_m1,
   input  logic                                 wr_en,
   input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] wr_addr,
   input  logic [PIXEL_BITS-1:0]                wr_data,
   output logic                                 rd_en,
   output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] rd_addr,
   input  logic [PIXEL_BITS-1:0]                rd_data,
   output logic                                 rsp_valid,
   output ifre_pkg::rsp_type                    rsp_item
);
   import ifre_pkg::*;

   localparam int IW = $clog2(MAX_ROWS);
   localparam int JW = $clog2(MAX_COLS);
   localparam int AW = $clog2(MAX_ROWS*MAX_COLS);

   logic                  loaded_ff, loaded_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [IW-1:0]         ri_ff, ri_in;
   logic [JW-1:0]         rj_ff, rj_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  not_ready_ff, not_ready_in;
   logic                  last_ff, last_in;
   logic                  fwd_ff, fwd_in;
   logic [PIXEL_BITS-1:0] fwd_data_ff;
   logic                  at_end;
   logic [PIXEL_BITS-1:0] pixel;

   // the output frame holds rows*cols pixels whatever its shape
   assign at_end  = (ri_ff == rows_m1) && (rj_ff == cols_m1);
   assign rd_en   = read && loaded_ff;
   assign rd_addr = ptr_ff;

   always_comb begin
      loaded_in    = loaded_ff;
      ptr_in       = ptr_ff;
      ri_in        = ri_ff;
      rj_in        = rj_ff;
      rsp_valid_in = read;
      not_ready_in = !loaded_ff;
      last_in      = loaded_ff && at_end;
      fwd_in       = wr_en && (wr_addr == ptr_ff);
      if (restart) begin
         loaded_in = 1'b0;
         ptr_in    = '0;
         ri_in     = '0;
         rj_in     = '0;
      end else if (evt.first || evt.done) begin
         if (evt.first) begin
            loaded_in = 1'b0;
            ptr_in    = '0;
            ri_in     = '0;
            rj_in     = '0;
         end
         if (evt.done) begin
            loaded_in = 1'b1;
         end
      end else if (rd_en) begin
         // advance, wrap to the first pixel after the last
         if (at_end) begin
            ptr_in = '0;
            ri_in  = '0;
            rj_in  = '0;
         end else begin
            ptr_in = ptr_ff + AW'(1);
            if (rj_ff == cols_m1) begin
               rj_in = '0;
               ri_in = ri_ff + IW'(1);
            end else begin
               rj_in = rj_ff + JW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= 1'b0;
         ptr_ff       <= '0;
         ri_ff        <= '0;
         rj_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         ptr_ff       <= ptr_in;
         ri_ff        <= ri_in;
         rj_ff        <= rj_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      not_ready_ff <= not_ready_in;
      last_ff      <= last_in;
      fwd_ff       <= fwd_in;
      fwd_data_ff  <= wr_data;
   end

   always_comb begin
      if (not_ready_ff) begin
         pixel = '0;
      end else if (fwd_ff) begin
         pixel = fwd_data_ff;
      end else begin
         pixel = rd_data;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_item.pixel_out  = PIXEL_W'(pixel);
   assign rsp_item.last_pixel = last_ff;
   assign rsp_item.not_ready  = not_ready_ff;

endmodule
